FILE: hw/rtl/breakpoint_address_table_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH
`define BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BAT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("breakpoint table check failed");

// Next-cycle implication, disabled while reset is held.
`define BAT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("breakpoint table check failed");

`endif

FILE: hw/rtl/bat_pkg.sv
`default_nettype none

package bat_pkg;

    // Default table geometry.
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_ADDR_BITS   = 16;

    // Fixed field widths on the stream ports.
    localparam int KIND_W        = 2;
    localparam int IN_ADDR_W     = 16;
    localparam int COUNT_FIELD_W = 5;
    localparam int OUT_W         = 8;

    // Operation codes carried in s_tuser.
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/breakpoint_address_table.sv
// The result beat turns valid once the input beat has passed a linear scan of the valid entries,
// the apply step and the post step; a hit ends the scan early, and removals add a move step.
// A new input beat is taken only after the previous one is handed to the output register, which
// waits while an earlier result is not taken; the single read port and one comparator set the pace.
// Reset: synchronous, active-low aresetn empties the table (count to zero) and drops any result;
// the entry memory itself is not cleared, since only entries below the count are ever compared.
`default_nettype none

module breakpoint_address_table
    import bat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = DEFAULT_ADDR_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_ADDR_W-1:0] s_tdata,   // [15:0] address
    input  wire logic [KIND_W-1:0]    s_tuser,   // [1:0] kind
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // [0] was_present, [1] now_present,
                                                 // [6:2] entry_count, [7] refused_full
);

    // Count must hold TABLE_DEPTH itself; the index only needs to reach TABLE_DEPTH - 1.
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Only the low bits of the 16-bit address field take part, and no more than ADDR_BITS.
    localparam int KEY_W = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an input beat
    localparam logic [2:0] S_SEARCH = 3'd1;  // scanning valid entries for the key
    localparam logic [2:0] S_APPLY  = 3'd2;  // decide the operation, insert if needed
    localparam logic [2:0] S_MOVE   = 3'd3;  // copy the last entry into the freed slot
    localparam logic [2:0] S_POST   = 3'd4;  // hand the result to the output register

    logic [2:0]        state_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;       // next entry to read during the scan
    logic [IDX_W-1:0]  cmp_idx_reg;   // entry whose data sits in rd_data_reg
    logic              cmp_vld_reg;   // rd_data_reg holds an entry still to compare
    logic              found_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              was_reg;
    logic              now_reg;
    logic              refused_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // Entry memory: one write port and one registered read port.
    logic [KEY_W-1:0]  entry_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  wr_data;

    logic [CNT_W-1:0]  last_cnt;
    logic              hit;
    logic              issue;
    logic              full;
    logic              do_insert;
    logic              do_remove;
    logic [31:0]       count_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign last_cnt  = count_reg - CNT_W'(1);
    assign count_ext = 32'(count_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));

    // The one comparator: the entry read last cycle against the key.
    assign hit   = cmp_vld_reg && (rd_data_reg == key_reg);
    assign issue = (idx_reg < count_reg);

    // A set, or a toggle of an absent address, inserts; a clear or toggle of a present one removes.
    assign do_insert = !found_reg && ((kind_reg == KIND_SET) || (kind_reg == KIND_TOGGLE));
    assign do_remove = found_reg && ((kind_reg == KIND_CLEAR) || (kind_reg == KIND_TOGGLE));

    // During the scan the read port walks the entries; in the apply step it fetches the last
    // valid entry so that a removal can move it into the freed slot.
    always_comb begin
        if (state_reg == S_APPLY) begin
            rd_idx = last_cnt[IDX_W-1:0];
        end else begin
            rd_idx = idx_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = count_reg[IDX_W-1:0];
        wr_data = key_reg;
        if (state_reg == S_APPLY && do_insert && !full) begin
            wr_en = 1'b1;
        end else if (state_reg == S_MOVE) begin
            wr_en   = 1'b1;
            wr_idx  = slot_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_mem[rd_idx];
        if (wr_en) begin
            entry_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The post step loads the next result itself, so the drain only acts outside it.
            if (m_tvalid_reg && m_tready && (state_reg != S_POST)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        key_reg     <= s_tdata[KEY_W-1:0];
                        kind_reg    <= s_tuser;
                        idx_reg     <= '0;
                        cmp_vld_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        state_reg   <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // Reads are issued one per cycle and each is compared in the next cycle.
                    if (hit) begin
                        found_reg   <= 1'b1;
                        slot_reg    <= cmp_idx_reg;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_APPLY;
                    end else if (issue) begin
                        cmp_idx_reg <= idx_reg[IDX_W-1:0];
                        cmp_vld_reg <= 1'b1;
                        idx_reg     <= idx_reg + CNT_W'(1);
                    end else if (cmp_vld_reg) begin
                        cmp_vld_reg <= 1'b0;
                    end else begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    was_reg     <= found_reg;
                    refused_reg <= 1'b0;
                    if (do_insert) begin
                        if (full) begin
                            refused_reg <= 1'b1;
                            now_reg     <= 1'b0;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                            now_reg   <= 1'b1;
                        end
                        state_reg <= S_POST;
                    end else if (do_remove) begin
                        now_reg   <= 1'b0;
                        state_reg <= S_MOVE;
                    end else begin
                        now_reg   <= found_reg;
                        state_reg <= S_POST;
                    end
                end
                S_MOVE: begin
                    count_reg <= last_cnt;
                    state_reg <= S_POST;
                end
                S_POST: begin
                    // Wait here only while an earlier result beat is still not taken.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {refused_reg, count_ext[COUNT_FIELD_W-1:0],
                                         now_reg, was_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bat_checker.sv
`default_nettype none

`include "breakpoint_address_table_assert.svh"

module bat_checker
    import bat_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // The table works on one beat at a time.
    `BAT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A refused insert means the address was absent and stays absent.
    `BAT_ASSERT_IMPLY(a_refused_absent, aclk, aresetn, m_tvalid && m_tdata[7], !m_tdata[0] && !m_tdata[1])

    // A present address keeps the count above zero.
    `BAT_ASSERT_IMPLY(a_present_counted, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[6:2] != 5'd0 || m_tdata[0])

    // A stalled result beat holds.
    `BAT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (.*);

`default_nettype wire

FILE: tb/breakpoint_table_checker.sv
module breakpoint_table_checker
    import bat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_BITS   = DEFAULT_ADDR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_ADDR_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    output int unsigned          fail_count,
    output int unsigned          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same layout as m_tdata: was_present in bit 0 up to refused_full in bit 7.
    typedef struct packed {
        logic                     refused_full;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     now_present;
        logic                     was_present;
    } table_result_t;

    typedef struct {
        logic [KIND_W-1:0]    op;
        logic [IN_ADDR_W-1:0] addr;
        table_result_t        outcome;
    } lookup_t;

    // Shadow copy of the breakpoint table.
    logic [ADDR_BITS-1:0] shadow_entries [TABLE_DEPTH];
    int unsigned          shadow_count;

    lookup_t       expected_lookups [$];
    lookup_t       oldest;
    lookup_t       incoming;
    table_result_t observed;

    function automatic int find_slot(input logic [ADDR_BITS-1:0] key);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic bit insert_key(input logic [ADDR_BITS-1:0] key);
        if (shadow_count >= TABLE_DEPTH)
            return 1'b1;
        shadow_entries[shadow_count] = key;
        shadow_count++;
        return 1'b0;
    endfunction

    // The last valid entry moves into the freed slot.
    function automatic void remove_slot(input int slot);
        shadow_entries[slot] = shadow_entries[shadow_count-1];
        shadow_count--;
    endfunction

    function automatic table_result_t apply_table_op(input logic [KIND_W-1:0]    op,
                                                     input logic [IN_ADDR_W-1:0] raw_addr);
        logic [ADDR_BITS-1:0] key;
        int                   slot;
        table_result_t        res;
        key = ADDR_BITS'(raw_addr);
        slot = find_slot(key);
        res = '0;
        res.was_present = (slot >= 0);
        case (op)
            KIND_SET: begin
                if (slot < 0)
                    res.refused_full = insert_key(key);
            end
            KIND_CLEAR: begin
                if (slot >= 0)
                    remove_slot(slot);
            end
            KIND_TOGGLE: begin
                if (slot >= 0)
                    remove_slot(slot);
                else
                    res.refused_full = insert_key(key);
            end
            default: begin
            end
        endcase
        res.now_present = (find_slot(key) >= 0);
        res.entry_count = COUNT_FIELD_W'(shadow_count);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = 0;
            fail_count   = 0;
            expected_lookups.delete();
        end else begin
            // Retire results first; a beat accepted in this cycle cannot have one yet.
            if (m_tvalid && m_tready) begin
                observed = table_result_t'(m_tdata);
                if (expected_lookups.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat 0x%02h arrived with nothing outstanding",
                             $time, m_tdata);
                end else begin
                    oldest = expected_lookups.pop_front();
                    if (observed !== oldest.outcome) begin
                        fail_count++;
                        $display({"%0t: kind %0d addr 0x%04h: expected was=%0b now=%0b ",
                                  "count=%0d refused=%0b, got was=%0b now=%0b count=%0d ",
                                  "refused=%0b"},
                                 $time, oldest.op, oldest.addr,
                                 oldest.outcome.was_present, oldest.outcome.now_present,
                                 oldest.outcome.entry_count, oldest.outcome.refused_full,
                                 observed.was_present, observed.now_present,
                                 observed.entry_count, observed.refused_full);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                incoming.op      = s_tuser;
                incoming.addr    = s_tdata;
                incoming.outcome = apply_table_op(s_tuser, s_tdata);
                expected_lookups.push_back(incoming);
            end
        end
        pending = expected_lookups.size();
    end

endmodule

FILE: tb/tb_breakpoint_address_table.sv
// Top level of the breakpoint table testbench. This module only generates clock, reset and
// stimulus and prints the verdict; the checker beside the block predicts every result beat
// and counts mismatches.
module tb_breakpoint_address_table;
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    localparam int          DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int          WIDTH        = DEFAULT_ADDR_BITS;
    localparam int          POOL_MAX     = 40;
    localparam int          RANDOM_SETS  = 19;
    localparam int          SET_LEN      = 100;
    // Extra wait after the last expected result, long enough to drain any straggler.
    localparam int          DRAIN_CYCLES = 40;
    // Long hold-off on the result side so the block backs up and stalls its input.
    localparam int          HOLD_START   = 3000;
    localparam int          HOLD_LEN     = 400;
    // Roughly 2000 beats fit well within this limit; allow far more.
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_ADDR_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = KIND_QUERY;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    int unsigned          fail_count;
    int unsigned          pending;

    // While calm is set neither side inserts idle cycles.
    bit                   calm = 1'b0;
    int unsigned          rx_cycle = 0;

    logic [IN_ADDR_W-1:0] addr_pool [POOL_MAX];
    int                   pool_size;
    int                   set_bias;
    int                   roll;
    logic [KIND_W-1:0]    op;
    logic [IN_ADDR_W-1:0] addr;

    always #2 aclk = ~aclk;

    breakpoint_address_table #(
        .TABLE_DEPTH (DEPTH),
        .ADDR_BITS   (WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    breakpoint_table_checker #(
        .TABLE_DEPTH (DEPTH),
        .ADDR_BITS   (WIDTH)
    ) checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offers one beat and returns at the falling edge after it was taken. It is entered at a
    // falling edge. Idle cycles drop tvalid first; tvalid is never lowered and raised in the
    // same step, so back-to-back beats keep it high.
    task automatic send_beat(input logic [KIND_W-1:0] k, input logic [IN_ADDR_W-1:0] a);
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= a;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result side: random back-pressure, a quiet stretch under calm, and one long hold-off
    // counted in its own cycles.
    initial begin
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 20);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_breakpoint_address_table failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Lookups on an empty table, both address extremes, a set of an address
        // that is already there, toggles in both directions, then the table is filled to the
        // brim so that set and toggle get refused; clears hit the first slot and an address that is
        // absent, and a toggle removes a middle slot.
        send_beat(KIND_QUERY,  16'h1234);
        send_beat(KIND_CLEAR,  16'hFFFF);
        send_beat(KIND_SET,    16'h0000);
        send_beat(KIND_SET,    16'hFFFF);
        send_beat(KIND_SET,    16'hFFFF);
        send_beat(KIND_TOGGLE, 16'hFFFF);
        send_beat(KIND_TOGGLE, 16'hFFFF);
        for (int i = 0; i < DEPTH - 2; i++)
            send_beat(KIND_SET, IN_ADDR_W'(1) << i);
        send_beat(KIND_SET,    16'hABCD);
        send_beat(KIND_TOGGLE, 16'h5555);
        send_beat(KIND_CLEAR,  16'h0000);
        send_beat(KIND_CLEAR,  16'h1234);
        send_beat(KIND_TOGGLE, 16'h0040);
        send_beat(KIND_QUERY,  16'h0040);

        // Random part, in sets of beats that share a small pool of addresses so that hits are
        // common. Pools smaller than the table let it drain, larger ones drive it to full.
        // Each set leans toward sets or toward removals by its own bias, and a few beats per
        // set use any address at all.
        for (int phase = 0; phase < RANDOM_SETS; phase++) begin
            calm = (phase == 5 || phase == 6);
            pool_size = $urandom_range(POOL_MAX, 2);
            for (int i = 0; i < POOL_MAX; i++)
                addr_pool[i] = IN_ADDR_W'($urandom);
            set_bias = $urandom_range(70, 10);
            for (int n = 0; n < SET_LEN; n++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    op   = KIND_W'($urandom);
                    addr = IN_ADDR_W'($urandom);
                end else begin
                    addr = addr_pool[$urandom_range(pool_size - 1)];
                    if ($urandom_range(99) < set_bias) begin
                        op = KIND_SET;
                    end else begin
                        case ($urandom_range(2))
                            0: op = KIND_QUERY;
                            1: op = KIND_CLEAR;
                            default: op = KIND_TOGGLE;
                        endcase
                    end
                end
                send_beat(op, addr);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Every beat is in; wait for the last results, then a little longer so that a stray
        // extra beat from the block would still be caught.
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("tb_breakpoint_address_table passed");
        end else begin
            $display("tb_breakpoint_address_table failed");
        end
        $finish;
    end

endmodule
